// File: src/assert_macros.svh
// Assertion macros used by the checker file of the allocator.
// Depends on nothing; the including module provides aclk and aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define SFLA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Clocked implication, disabled while reset is asserted.
`define SFLA_ASSERT_IMP(label, pre, post, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error(msg);

`endif

// File: src/sfla_pkg.sv
// Package of the segregated free-list allocator: payload types, codes, sizes.
// Depends on nothing; used by the core and by the checker.
package sfla_pkg;

    localparam int MAX_BLOCKS  = 256;
    localparam int MAX_CLASSES = 16;
    localparam int IDX_W       = $clog2(MAX_BLOCKS);
    localparam int SIZE_W      = 20;

    // Commands.
    localparam logic [1:0] CMD_INIT    = 2'd0;
    localparam logic [1:0] CMD_ALLOC   = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;
    localparam logic [1:0] CMD_CHECK   = 2'd3;

    // Status codes.
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_OOM         = 3'd1;
    localparam logic [2:0] ST_BAD_RELEASE = 3'd2;
    localparam logic [2:0] ST_IGNORED     = 3'd3;
    localparam logic [2:0] ST_FAULT       = 3'd4;
    localparam logic [2:0] ST_FULL        = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] REG_HEAP_START  = 2'd0;
    localparam logic [1:0] REG_CLASS_COUNT = 2'd1;
    localparam logic [1:0] REG_BYTES_CLASS = 2'd2;

    typedef struct packed {
        logic [1:0]  command;
        logic [24:0] request_size;
        logic [31:0] target_address;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] granted_address;
        logic [31:0] total_heap_bytes;
        logic [31:0] allocated_bytes;
        logic [12:0] free_block_total;
        logic [12:0] allocated_block_total;
        logic [31:0] alloc_call_count;
        logic [31:0] split_count;
        logic [31:0] release_call_count;
    } out_item_t;

    // One block table entry; its valid mark lives in flip-flops.
    typedef struct packed {
        logic              used;
        logic [31:0]       start;
        logic [SIZE_W-1:0] size;
    } entry_t;

endpackage

// File: src/segregated_free_list_allocator_core.sv
// Segregated free-list allocator core: block table memory and its sequencer; uses sfla_pkg.
// Allocate and release: one full table scan at one entry per cycle, then an update (and a
// split write when a block is split) and the result; the input reopens as the result is offered.
// Init builds the blocks class by class. Check: up to 257 table scans.
// Zero-size allocate and release of address zero skip the scan and answer at once.
// Reset (aresetn low, synchronous) clears valid marks and statistics and resets the config registers.
module segregated_free_list_allocator_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sfla_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sfla_pkg::out_item_t  m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data
);

    localparam int IW = sfla_pkg::IDX_W;
    localparam int SW = sfla_pkg::SIZE_W;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_INIT   = 6'b000010,
        S_SCAN   = 6'b000100,
        S_UPDATE = 6'b001000,
        S_SPLIT  = 6'b010000,
        S_RESP   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [31:0] heap_start_reg;
    logic [4:0]  class_count_reg;
    logic [20:0] bpc_reg;

    // Statistics.
    logic [31:0] heap_total_reg, heap_total_next;
    logic [31:0] bytes_reg, bytes_next;
    logic [12:0] free_reg, free_next;
    logic [12:0] used_reg, used_next;
    logic [31:0] allocs_reg, allocs_next;
    logic [31:0] splits_reg, splits_next;
    logic [31:0] releases_reg, releases_next;

    // Current command.
    logic [1:0]  cmd_reg, cmd_next;
    logic [24:0] req_reg, req_next;
    logic [31:0] addr_reg, addr_next;

    // Init sequencer.
    logic [4:0]    cls_reg, cls_next;
    logic [4:0]    ncls_reg, ncls_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [17:0]   cnt_reg, cnt_next;
    logic [IW:0]   slot_reg, slot_next;
    logic [31:0]   baddr_reg, baddr_next;

    // Scan control.
    logic [IW:0]   idx_reg, idx_next;
    logic          evld_reg, evld_next;
    logic [IW-1:0] eidx_reg, eidx_next;

    // Scan findings.
    logic          hit_reg, hit_next;
    logic [IW-1:0] hidx_reg, hidx_next;
    logic [31:0]   hstart_reg, hstart_next;
    logic [SW-1:0] hsize_reg, hsize_next;
    logic          spare_reg, spare_next;
    logic [IW-1:0] sidx_reg, sidx_next;

    // Check walk.
    logic [32:0] cur_reg, cur_next;
    logic [24:0] left_reg, left_next;
    logic [IW:0] step_reg, step_next;

    // Result.
    logic [2:0]  rstat_reg, rstat_next;
    logic [31:0] rgrant_reg, rgrant_next;
    logic        m_valid_reg, m_valid_next;
    sfla_pkg::out_item_t m_data_reg, m_data_next;

    // Valid marks and table memory.
    logic [sfla_pkg::MAX_BLOCKS-1:0] valid_reg, valid_next;
    sfla_pkg::entry_t mem [sfla_pkg::MAX_BLOCKS];
    sfla_pkg::entry_t rdata_reg;
    sfla_pkg::entry_t wdata;
    logic             we;
    logic [IW-1:0]    waddr;

    // Evaluation helpers.
    logic        ev_valid;
    logic [32:0] ev_end;
    logic [32:0] hend;
    logic [32:0] room;
    logic [4:0]  n_eff;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign ev_valid = valid_reg[eidx_reg];
    assign ev_end   = {1'b0, rdata_reg.start} + {13'd0, rdata_reg.size};
    assign hend     = {1'b0, hstart_reg} + {13'd0, hsize_reg};
    assign room     = hend - cur_reg;
    assign n_eff    = (class_count_reg > 5'(sfla_pkg::MAX_CLASSES)) ?
                      5'(sfla_pkg::MAX_CLASSES) : class_count_reg;

    // Table memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[idx_reg[IW-1:0]];
    end

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_start_reg  <= '0;
            class_count_reg <= 5'd1;
            bpc_reg         <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                sfla_pkg::REG_HEAP_START:  heap_start_reg  <= cfg_data;
                sfla_pkg::REG_CLASS_COUNT: class_count_reg <= cfg_data[4:0];
                sfla_pkg::REG_BYTES_CLASS: bpc_reg         <= cfg_data[20:0];
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb begin
        state_next    = state_reg;
        heap_total_next = heap_total_reg;
        bytes_next    = bytes_reg;
        free_next     = free_reg;
        used_next     = used_reg;
        allocs_next   = allocs_reg;
        splits_next   = splits_reg;
        releases_next = releases_reg;
        cmd_next      = cmd_reg;
        req_next      = req_reg;
        addr_next     = addr_reg;
        cls_next      = cls_reg;
        ncls_next     = ncls_reg;
        sz_next       = sz_reg;
        cnt_next      = cnt_reg;
        slot_next     = slot_reg;
        baddr_next    = baddr_reg;
        idx_next      = idx_reg;
        evld_next     = 1'b0;
        eidx_next     = idx_reg[IW-1:0];
        hit_next      = hit_reg;
        hidx_next     = hidx_reg;
        hstart_next   = hstart_reg;
        hsize_next    = hsize_reg;
        spare_next    = spare_reg;
        sidx_next     = sidx_reg;
        cur_next      = cur_reg;
        left_next     = left_reg;
        step_next     = step_reg;
        rstat_next    = rstat_reg;
        rgrant_next   = rgrant_reg;
        valid_next    = valid_reg;
        m_valid_next  = m_valid_reg;
        m_data_next   = m_data_reg;
        we            = 1'b0;
        waddr         = '0;
        wdata         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_next    = s_data.command;
                    req_next    = s_data.request_size;
                    addr_next   = s_data.target_address;
                    idx_next    = '0;
                    hit_next    = 1'b0;
                    spare_next  = 1'b0;
                    rgrant_next = '0;
                    rstat_next  = sfla_pkg::ST_OK;
                    cur_next    = {1'b0, s_data.target_address};
                    left_next   = s_data.request_size;
                    step_next   = '0;
                    case (s_data.command)
                        sfla_pkg::CMD_INIT: begin
                            valid_next      = '0;
                            bytes_next      = '0;
                            free_next       = '0;
                            used_next       = '0;
                            allocs_next     = '0;
                            splits_next     = '0;
                            releases_next   = '0;
                            heap_total_next = 32'(n_eff) * 32'(bpc_reg);
                            ncls_next       = n_eff;
                            cls_next        = '0;
                            sz_next         = SW'(8);
                            cnt_next        = 18'(bpc_reg >> 3);
                            slot_next       = '0;
                            baddr_next      = heap_start_reg;
                            state_next      = S_INIT;
                        end
                        sfla_pkg::CMD_ALLOC: begin
                            if (s_data.request_size == '0) begin
                                rstat_next = sfla_pkg::ST_IGNORED;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        sfla_pkg::CMD_RELEASE: begin
                            if (s_data.target_address == '0) begin
                                rstat_next = sfla_pkg::ST_IGNORED;
                                state_next = S_RESP;
                            end else begin
                                state_next = S_SCAN;
                            end
                        end
                        default: begin
                            state_next = S_SCAN;
                        end
                    endcase
                end
            end

            // Build one block per cycle, class by class.
            S_INIT: begin
                if (cls_reg == ncls_reg) begin
                    state_next = S_RESP;
                end else if (cnt_reg == '0) begin
                    cls_next = cls_reg + 5'd1;
                    sz_next  = sz_reg << 1;
                    cnt_next = 18'(bpc_reg >> (cls_reg + 5'd4));
                end else if (slot_reg[IW]) begin
                    rstat_next = sfla_pkg::ST_FULL;
                    state_next = S_RESP;
                end else begin
                    we         = 1'b1;
                    waddr      = slot_reg[IW-1:0];
                    wdata      = '{used: 1'b0, start: baddr_reg, size: sz_reg};
                    valid_next[slot_reg[IW-1:0]] = 1'b1;
                    free_next  = free_reg + 13'd1;
                    slot_next  = slot_reg + (IW+1)'(1);
                    baddr_next = baddr_reg + 32'(sz_reg);
                    cnt_next   = cnt_reg - 18'd1;
                end
            end

            // Issue one read per cycle and judge the entry read last cycle.
            S_SCAN: begin
                if (!idx_reg[IW]) begin
                    idx_next  = idx_reg + (IW+1)'(1);
                    evld_next = 1'b1;
                end
                if (evld_reg) begin
                    case (cmd_reg)
                        sfla_pkg::CMD_ALLOC: begin
                            if (!ev_valid) begin
                                if (!spare_reg) begin
                                    spare_next = 1'b1;
                                    sidx_next  = eidx_reg;
                                end
                            end else if (!rdata_reg.used &&
                                         25'(rdata_reg.size) >= req_reg) begin
                                if (!hit_reg || rdata_reg.size < hsize_reg ||
                                    (rdata_reg.size == hsize_reg &&
                                     rdata_reg.start < hstart_reg)) begin
                                    hit_next    = 1'b1;
                                    hidx_next   = eidx_reg;
                                    hstart_next = rdata_reg.start;
                                    hsize_next  = rdata_reg.size;
                                end
                            end
                        end
                        sfla_pkg::CMD_RELEASE: begin
                            if (!hit_reg && ev_valid && rdata_reg.used &&
                                rdata_reg.start == addr_reg) begin
                                hit_next    = 1'b1;
                                hidx_next   = eidx_reg;
                                hsize_next  = rdata_reg.size;
                                hstart_next = rdata_reg.start;
                            end
                        end
                        default: begin
                            if (ev_valid && rdata_reg.used &&
                                cur_reg >= {1'b0, rdata_reg.start} &&
                                cur_reg < ev_end) begin
                                hit_next    = 1'b1;
                                hstart_next = rdata_reg.start;
                                hsize_next  = rdata_reg.size;
                                evld_next   = 1'b0;
                                state_next  = S_UPDATE;
                            end
                        end
                    endcase
                end
                if (idx_reg[IW] && !evld_reg) begin
                    state_next = S_UPDATE;
                end
            end

            // Apply the outcome of a finished scan.
            S_UPDATE: begin
                case (cmd_reg)
                    sfla_pkg::CMD_ALLOC: begin
                        state_next = S_RESP;
                        if (!hit_reg) begin
                            rstat_next = sfla_pkg::ST_OOM;
                        end else if (25'(hsize_reg) != req_reg && !spare_reg) begin
                            rstat_next = sfla_pkg::ST_FULL;
                        end else begin
                            we          = 1'b1;
                            waddr       = hidx_reg;
                            wdata       = '{used: 1'b1, start: hstart_reg,
                                            size: req_reg[SW-1:0]};
                            used_next   = used_reg + 13'd1;
                            allocs_next = allocs_reg + 32'd1;
                            bytes_next  = bytes_reg + 32'(req_reg);
                            rgrant_next = hstart_reg;
                            if (25'(hsize_reg) != req_reg) begin
                                splits_next = splits_reg + 32'd1;
                                state_next  = S_SPLIT;
                            end else begin
                                free_next = free_reg - 13'd1;
                            end
                        end
                    end
                    sfla_pkg::CMD_RELEASE: begin
                        state_next = S_RESP;
                        if (!hit_reg) begin
                            rstat_next = sfla_pkg::ST_BAD_RELEASE;
                        end else begin
                            we            = 1'b1;
                            waddr         = hidx_reg;
                            wdata         = '{used: 1'b0, start: hstart_reg,
                                              size: hsize_reg};
                            bytes_next    = bytes_reg - 32'(hsize_reg);
                            used_next     = used_reg - 13'd1;
                            free_next     = free_reg + 13'd1;
                            releases_next = releases_reg + 32'd1;
                        end
                    end
                    default: begin
                        if (!hit_reg) begin
                            rstat_next = sfla_pkg::ST_FAULT;
                            state_next = S_RESP;
                        end else if ({8'd0, left_reg} <= room) begin
                            state_next = S_RESP;
                        end else if (step_reg[IW]) begin
                            rstat_next = sfla_pkg::ST_FAULT;
                            state_next = S_RESP;
                        end else begin
                            // Continue the walk at the end of this block.
                            left_next  = left_reg - 25'(room);
                            cur_next   = hend;
                            step_next  = step_reg + (IW+1)'(1);
                            hit_next   = 1'b0;
                            idx_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end

            // Write the free remainder of a split block.
            S_SPLIT: begin
                we    = 1'b1;
                waddr = sidx_reg;
                wdata = '{used: 1'b0, start: hstart_reg + 32'(req_reg),
                          size: hsize_reg - req_reg[SW-1:0]};
                valid_next[sidx_reg] = 1'b1;
                state_next = S_RESP;
            end

            // Load the output register once it is free.
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{status:                rstat_reg,
                                     granted_address:       rgrant_reg,
                                     total_heap_bytes:      heap_total_reg,
                                     allocated_bytes:       bytes_reg,
                                     free_block_total:      free_reg,
                                     allocated_block_total: used_reg,
                                     alloc_call_count:      allocs_reg,
                                     split_count:           splits_reg,
                                     release_call_count:    releases_reg};
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            heap_total_reg <= '0;
            bytes_reg      <= '0;
            free_reg       <= '0;
            used_reg       <= '0;
            allocs_reg     <= '0;
            splits_reg     <= '0;
            releases_reg   <= '0;
            valid_reg      <= '0;
            m_valid_reg    <= 1'b0;
            evld_reg       <= 1'b0;
            idx_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            heap_total_reg <= heap_total_next;
            bytes_reg      <= bytes_next;
            free_reg       <= free_next;
            used_reg       <= used_next;
            allocs_reg     <= allocs_next;
            splits_reg     <= splits_next;
            releases_reg   <= releases_next;
            valid_reg      <= valid_next;
            m_valid_reg    <= m_valid_next;
            evld_reg       <= evld_next;
            idx_reg        <= idx_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        req_reg    <= req_next;
        addr_reg   <= addr_next;
        cls_reg    <= cls_next;
        ncls_reg   <= ncls_next;
        sz_reg     <= sz_next;
        cnt_reg    <= cnt_next;
        slot_reg   <= slot_next;
        baddr_reg  <= baddr_next;
        eidx_reg   <= eidx_next;
        hit_reg    <= hit_next;
        hidx_reg   <= hidx_next;
        hstart_reg <= hstart_next;
        hsize_reg  <= hsize_next;
        spare_reg  <= spare_next;
        sidx_reg   <= sidx_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        step_reg   <= step_next;
        rstat_reg  <= rstat_next;
        rgrant_reg <= rgrant_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: src/sfla_checker.sv
// Port-level checker of the allocator core, attached by bind.
// Depends on sfla_pkg and assert_macros.svh.
`include "assert_macros.svh"

module sfla_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input sfla_pkg::out_item_t m_data
);

    logic [13:0] block_sum;

    assign block_sum = 14'(m_data.free_block_total) + 14'(m_data.allocated_block_total);

    // A stalled result transaction stays offered and unchanged.
    `SFLA_ASSERT(a_m_hold, m_valid && !m_ready |=> m_valid, "result dropped while stalled")
    `SFLA_ASSERT(a_m_stable, m_valid && !m_ready |=> $stable(m_data), "result changed")

    // An accepted command keeps the input closed on the next cycle.
    `SFLA_ASSERT(a_s_busy, s_valid && s_ready |=> !s_ready, "input open after accept")

    // Only a successful allocate grants an address.
    `SFLA_ASSERT_IMP(a_grant, m_valid && m_data.status != sfla_pkg::ST_OK,
                     m_data.granted_address == '0, "address granted on failure")

    // The table never holds more blocks than it has entries.
    `SFLA_ASSERT_IMP(a_count, m_valid, block_sum <= 14'(sfla_pkg::MAX_BLOCKS), "block overflow")

endmodule

bind segregated_free_list_allocator_core sfla_checker u_sfla_checker (.*);

// File: test/segregated_free_list_allocator_core_test.sv
// Self-checking testbench of the segregated free-list allocator core.
// Depends on sfla_pkg and on segregated_free_list_allocator_core; it predicts
// every result with its own block table and compares it field by field.
module segregated_free_list_allocator_core_test;

    localparam int TABLE_DEPTH = sfla_pkg::MAX_BLOCKS;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int LONG_STALL  = 3000;

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    sfla_pkg::in_item_t  s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    sfla_pkg::out_item_t m_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [1:0]          cfg_index = sfla_pkg::REG_HEAP_START;
    logic [31:0]         cfg_data = '0;

    segregated_free_list_allocator_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Shadow heap: block table, statistics and configuration.
    bit          blk_valid [TABLE_DEPTH];
    bit          blk_used  [TABLE_DEPTH];
    logic [31:0] blk_start [TABLE_DEPTH];
    logic [31:0] blk_size  [TABLE_DEPTH];
    logic [31:0] heap_bytes, bytes_taken, free_count, used_count;
    logic [31:0] allocs_done, splits_done, releases_done;
    logic [31:0] base_addr = '0;
    logic [4:0]  classes = 5'd1;
    logic [20:0] class_bytes = '0;

    sfla_pkg::in_item_t  cmd_backlog[$];
    sfla_pkg::out_item_t predicted_results[$];
    logic [31:0] live_grants[$];
    int          src_idle = 0;
    int          rx_idle = 0;
    int          stall_requests = 0;
    int          stall_served = 0;
    int          stall_left = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          accepted_cmds = 0;
    int          status_seen[8];

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Verification failed");
            $finish;
        end
    end

    function automatic void clear_heap();
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            blk_valid[i] = 0;
            blk_used[i] = 0;
        end
        heap_bytes = '0; bytes_taken = '0; free_count = '0; used_count = '0;
        allocs_done = '0; splits_done = '0; releases_done = '0;
        live_grants.delete();
    endfunction

    function automatic logic [2:0] build_heap();
        int          n;
        int          slot;
        logic [31:0] addr;
        logic [31:0] sz;
        logic [31:0] cnt;
        bit          full;
        n = (classes > sfla_pkg::MAX_CLASSES) ? sfla_pkg::MAX_CLASSES : classes;
        slot = 0;
        addr = base_addr;
        full = 0;
        clear_heap();
        heap_bytes = n * class_bytes;
        for (int i = 0; i < n && !full; i++) begin
            sz = 32'd8 << i;
            cnt = class_bytes / sz;
            for (int j = 0; j < cnt; j++) begin
                if (slot >= TABLE_DEPTH) begin
                    full = 1;
                    break;
                end
                blk_valid[slot] = 1;
                blk_used[slot] = 0;
                blk_start[slot] = addr;
                blk_size[slot] = sz;
                slot++;
                free_count++;
                addr += sz;
            end
        end
        return full ? sfla_pkg::ST_FULL : sfla_pkg::ST_OK;
    endfunction

    // Best fit: smallest free block that fits, lowest start among equals.
    function automatic logic [2:0] take_block(input logic [31:0] req,
                                              output logic [31:0] granted);
        int best;
        int spare;
        best = -1;
        spare = -1;
        granted = '0;
        if (req == 0) return sfla_pkg::ST_IGNORED;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!blk_valid[i]) begin
                if (spare < 0) spare = i;
            end else if (!blk_used[i] && blk_size[i] >= req) begin
                if (best < 0 || blk_size[i] < blk_size[best] ||
                    (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best]))
                    best = i;
            end
        end
        if (best < 0) return sfla_pkg::ST_OOM;
        if (blk_size[best] != req) begin
            if (spare < 0) return sfla_pkg::ST_FULL;
            blk_valid[spare] = 1;
            blk_used[spare] = 0;
            blk_start[spare] = blk_start[best] + req;
            blk_size[spare] = blk_size[best] - req;
            blk_size[best] = req;
            splits_done++;
        end else begin
            free_count--;
        end
        blk_used[best] = 1;
        used_count++;
        allocs_done++;
        bytes_taken += req;
        granted = blk_start[best];
        live_grants.push_back(granted);
        return sfla_pkg::ST_OK;
    endfunction

    function automatic logic [2:0] give_back(input logic [31:0] addr);
        int hits[$];
        if (addr == 0) return sfla_pkg::ST_IGNORED;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (blk_valid[i] && blk_used[i] && blk_start[i] == addr) begin
                blk_used[i] = 0;
                bytes_taken -= blk_size[i];
                used_count--;
                free_count++;
                releases_done++;
                hits = live_grants.find_first_index(g) with (g == addr);
                if (hits.size() > 0) live_grants.delete(hits[0]);
                return sfla_pkg::ST_OK;
            end
        end
        return sfla_pkg::ST_BAD_RELEASE;
    endfunction

    // Walks a chain of address-contiguous allocated blocks covering the range.
    function automatic logic [2:0] range_covered(input logic [31:0] addr,
                                                 input logic [31:0] len);
        longint unsigned cur;
        longint unsigned left;
        longint unsigned s;
        longint unsigned e;
        int hit;
        cur = addr;
        left = len;
        for (int step = 0; step <= TABLE_DEPTH; step++) begin
            hit = -1;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                s = blk_start[i];
                if (blk_valid[i] && blk_used[i] && cur >= s &&
                    cur < s + blk_size[i]) begin
                    hit = i;
                    break;
                end
            end
            if (hit < 0) return sfla_pkg::ST_FAULT;
            e = longint'(blk_start[hit]) + blk_size[hit];
            if (left <= e - cur) return sfla_pkg::ST_OK;
            left -= e - cur;
            cur = e;
        end
        return sfla_pkg::ST_FAULT;
    endfunction

    function automatic sfla_pkg::out_item_t heap_response(input sfla_pkg::in_item_t it);
        sfla_pkg::out_item_t r;
        logic [31:0]         granted;
        granted = '0;
        case (it.command)
            sfla_pkg::CMD_INIT:    r.status = build_heap();
            sfla_pkg::CMD_ALLOC:   r.status = take_block({7'd0, it.request_size}, granted);
            sfla_pkg::CMD_RELEASE: r.status = give_back(it.target_address);
            default: r.status = range_covered(it.target_address, {7'd0, it.request_size});
        endcase
        r.granted_address = granted;
        r.total_heap_bytes = heap_bytes;
        r.allocated_bytes = bytes_taken;
        r.free_block_total = free_count[12:0];
        r.allocated_block_total = used_count[12:0];
        r.alloc_call_count = allocs_done;
        r.split_count = splits_done;
        r.release_call_count = releases_done;
        return r;
    endfunction

    // Driver: predicts each accepted transaction and offers the next one.
    always @(posedge aclk) begin
        if (aresetn && !(s_valid && !s_ready)) begin
            if (s_valid) begin
                predicted_results.push_back(heap_response(s_data));
                accepted_cmds++;
            end
            if (cmd_backlog.size() > 0 && $urandom_range(99) >= src_idle) begin
                s_valid <= 1'b1;
                s_data <= cmd_backlog.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("Mismatch in %s: got %h, expected %h (cycle %0d)", field, got, want, cycles);
    endtask

    // Long receiver stall, counted in cycles on its own.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
            end else if (stall_served != stall_requests) begin
                stall_served <= stall_served + 1;
                stall_left <= LONG_STALL;
            end
        end
    end

    // Monitor: checks results and drives the receiver side.
    always @(posedge aclk) begin
        sfla_pkg::out_item_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (predicted_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_data.status, '0);
                end else begin
                    want = predicted_results.pop_front();
                    status_seen[want.status]++;
                    if (m_data.status !== want.status)
                        report_mismatch("status", m_data.status, want.status);
                    if (m_data.granted_address !== want.granted_address)
                        report_mismatch("granted_address", m_data.granted_address,
                                        want.granted_address);
                    if (m_data.total_heap_bytes !== want.total_heap_bytes)
                        report_mismatch("total_heap_bytes", m_data.total_heap_bytes,
                                        want.total_heap_bytes);
                    if (m_data.allocated_bytes !== want.allocated_bytes)
                        report_mismatch("allocated_bytes", m_data.allocated_bytes,
                                        want.allocated_bytes);
                    if (m_data.free_block_total !== want.free_block_total)
                        report_mismatch("free_block_total", m_data.free_block_total,
                                        want.free_block_total);
                    if (m_data.allocated_block_total !== want.allocated_block_total)
                        report_mismatch("allocated_block_total",
                                        m_data.allocated_block_total,
                                        want.allocated_block_total);
                    if (m_data.alloc_call_count !== want.alloc_call_count)
                        report_mismatch("alloc_call_count", m_data.alloc_call_count,
                                        want.alloc_call_count);
                    if (m_data.split_count !== want.split_count)
                        report_mismatch("split_count", m_data.split_count,
                                        want.split_count);
                    if (m_data.release_call_count !== want.release_call_count)
                        report_mismatch("release_call_count", m_data.release_call_count,
                                        want.release_call_count);
                end
            end
            if (stall_left > 0 || stall_served != stall_requests) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            sfla_pkg::REG_HEAP_START:  base_addr = val;
            sfla_pkg::REG_CLASS_COUNT: classes = val[4:0];
            sfla_pkg::REG_BYTES_CLASS: class_bytes = val[20:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        while (cmd_backlog.size() > 0 || s_valid || predicted_results.size() > 0)
            @(posedge aclk);
    endtask

    function automatic sfla_pkg::in_item_t make_cmd(input logic [1:0] cmd,
                                                    input logic [31:0] size,
                                                    input logic [31:0] addr);
        sfla_pkg::in_item_t it;
        it.command = cmd;
        it.request_size = size[24:0];
        it.target_address = addr;
        return it;
    endfunction

    // Random command, mostly well-formed against the live allocations.
    function automatic sfla_pkg::in_item_t random_cmd();
        int          r;
        logic [31:0] size;
        logic [31:0] addr;
        r = $urandom_range(99);
        addr = (live_grants.size() > 0) ?
               live_grants[$urandom_range(live_grants.size() - 1)] : $urandom;
        if (r < 3) return make_cmd(sfla_pkg::CMD_INIT, $urandom, $urandom);
        if (r < 45) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: size = 32'd8 << $urandom_range(5);
                6, 7:             size = $urandom_range(1, 300);
                8:                size = $urandom_range(1, 4096);
                default:          size = $urandom_range(0, 25'h1FF_FFFF);
            endcase
            return make_cmd(sfla_pkg::CMD_ALLOC, size, $urandom);
        end
        if (r < 75) begin
            if ($urandom_range(99) < 85)
                return make_cmd(sfla_pkg::CMD_RELEASE, $urandom, addr);
            return make_cmd(sfla_pkg::CMD_RELEASE, $urandom,
                            ($urandom_range(1)) ? 32'd0 : $urandom);
        end
        if (r < 95)
            return make_cmd(sfla_pkg::CMD_CHECK, $urandom_range(64),
                            addr + $urandom_range(7));
        return make_cmd($urandom_range(3), $urandom, $urandom);
    endfunction

    // Phase settings: base address, class count and bytes per class.
    logic [31:0] phase_base  [6] = '{32'h0000_1000, 32'hFFFF_FF00, 32'h0000_0000,
                                     32'h8000_0000, 32'hFFFF_FFFF, 32'h1234_5678};
    logic [31:0] phase_class [6] = '{32'd4, 32'd3, 32'd16, 32'd31, 32'd1, 32'd6};
    logic [31:0] phase_bytes [6] = '{32'd512, 32'd256, 32'd1048576, 32'd64, 32'd0,
                                     32'h001F_FFFF};

    initial begin
        clear_heap();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Commands against the empty heap of the reset settings.
        src_idle <= 27;
        rx_idle <= 58;
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 0, 0));
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 8, 0));
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_RELEASE, 0, 0));
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_RELEASE, 0, 32'h1000));
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 0, 0));
        cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_INIT, 0, 0));
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            if (p == 2) begin
                src_idle <= 58;
                rx_idle <= 27;
            end else if (p == 4) begin
                src_idle <= 0;
                rx_idle <= 0;
            end
            write_reg(sfla_pkg::REG_HEAP_START, phase_base[p]);
            write_reg(sfla_pkg::REG_CLASS_COUNT, phase_class[p]);
            write_reg(sfla_pkg::REG_BYTES_CLASS, phase_bytes[p]);
            cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_INIT, 0, 0));
            if (p == 0) begin
                // Exact fit, split, oversize requests and ranges over both blocks.
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 8, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 5, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 32'h100_0000, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 32'h1FF_FFFF, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 13, 32'h1000));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 9, 32'h1004));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 14, 32'h1000));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 0, 32'h100C));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 32'h1FF_FFFF,
                                               32'hFFFF_FFFF));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_RELEASE, 0, 32'h1000));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_RELEASE, 0, 32'h1000));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_CHECK, 0, 32'h1000));
            end else if (p == 2) begin
                // Full table: a split has no spare entry.
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 5, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_ALLOC, 8, 0));
                cmd_backlog.push_back(make_cmd(sfla_pkg::CMD_RELEASE, 0, 0));
            end
            for (int n = 0; n < 265; n++) begin
                while (cmd_backlog.size() > 1) @(posedge aclk);
                if (p == 1 && n == 100) stall_requests++;
                cmd_backlog.push_back(random_cmd());
            end
            wait_idle();
        end

        repeat (300) @(posedge aclk);
        $display("Ran %0d commands over 6 heap layouts plus the reset layout.", accepted_cmds);
        $display("Status counts: ok %0d, oom %0d, bad release %0d, ignored %0d, %s %0d, %s %0d",
                 status_seen[sfla_pkg::ST_OK], status_seen[sfla_pkg::ST_OOM],
                 status_seen[sfla_pkg::ST_BAD_RELEASE], status_seen[sfla_pkg::ST_IGNORED],
                 "fault", status_seen[sfla_pkg::ST_FAULT],
                 "full", status_seen[sfla_pkg::ST_FULL]);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
